/* sv/fftu_pkg.sv */
package fftu_pkg;

  // widths of the fields
  localparam int BYTE_W    = 8;
  localparam int CLUSTER_W = 16;
  localparam int NEXT_W    = CLUSTER_W + 1;
  localparam int PHASE_W   = 3;

  // counts below this select 12-bit entries
  localparam logic [CLUSTER_W-1:0] NARROW_LIMIT = 16'd4096;

  // last header byte position for each entry width
  localparam logic [PHASE_W-1:0] HDR_LAST_NARROW = 3'd2;
  localparam logic [PHASE_W-1:0] HDR_LAST_WIDE   = 3'd3;

  // byte positions inside an entry group
  localparam logic [PHASE_W-1:0] PHASE_FIRST  = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_SECOND = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_THIRD  = 3'd2;

  // first cluster after the reserved entries
  localparam logic [NEXT_W-1:0] FIRST_CLUSTER = 17'd2;

  // one unpacked entry on its way from front to back
  typedef struct packed {
    logic [CLUSTER_W-1:0] cluster;
    logic [CLUSTER_W-1:0] value;
    logic                 last;
    logic                 fresh;
  } entry_t;

endpackage

/* sv/fftu_if.sv */
interface fftu_byte_if;
  import fftu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] table_byte;
  logic              table_start;

  modport source (output valid, output table_byte, output table_start, input ready);
  modport sink (input valid, input table_byte, input table_start, output ready);
endinterface

interface fftu_entry_if;
  import fftu_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CLUSTER_W-1:0] cluster_number;
  logic [CLUSTER_W-1:0] entry_value;
  logic [CLUSTER_W-1:0] highest_used;
  logic                 last_entry;

  modport source (
    output valid, output cluster_number, output entry_value,
    output highest_used, output last_entry, input ready
  );
  modport sink (
    input valid, input cluster_number, input entry_value,
    input highest_used, input last_entry, output ready
  );
endinterface

/* sv/fftu_front.sv */
module fftu_front
  import fftu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CLUSTER_W-1:0] cluster_count,
  fftu_byte_if.sink            bytes,
  output logic                 push_valid,
  input  logic                 push_ready,
  output entry_t               push_word
);

  logic [PHASE_W-1:0]   byte_phase, byte_phase_next;
  logic [CLUSTER_W-1:0] held_bytes, held_bytes_next;
  logic [NEXT_W-1:0]    next_cluster, next_cluster_next;
  logic                 header_skipped, header_skipped_next;
  logic                 fresh_pending, fresh_pending_next;

  logic [PHASE_W-1:0]   phase0;
  logic [CLUSTER_W-1:0] held0;
  logic [NEXT_W-1:0]    nc0;
  logic                 hs0;
  logic                 fresh0;
  logic                 narrow;
  logic                 accept;
  logic                 emit;
  logic [CLUSTER_W-1:0] value;
  logic [PHASE_W-1:0]   hdr_last;

  assign accept      = bytes.valid && push_ready;
  assign bytes.ready = push_ready;
  assign narrow      = cluster_count < NARROW_LIMIT;
  assign hdr_last    = narrow ? HDR_LAST_NARROW : HDR_LAST_WIDE;

  // restart on table start, then classify the byte
  always_comb begin
    phase0  = bytes.table_start ? PHASE_FIRST : byte_phase;
    held0   = bytes.table_start ? '0 : held_bytes;
    nc0     = bytes.table_start ? FIRST_CLUSTER : next_cluster;
    hs0     = bytes.table_start ? 1'b0 : header_skipped;
    fresh0  = bytes.table_start || fresh_pending;

    byte_phase_next     = phase0;
    held_bytes_next     = held0;
    header_skipped_next = hs0;
    emit                = 1'b0;
    value               = '0;

    if (nc0 > {1'b0, cluster_count}) begin
      // past the end of the table: ignore
    end else if (!hs0) begin
      if (phase0 >= hdr_last) begin
        header_skipped_next = 1'b1;
        byte_phase_next     = PHASE_FIRST;
      end else begin
        byte_phase_next = phase0 + 3'd1;
      end
    end else if (narrow) begin
      if (phase0 == PHASE_FIRST) begin
        held_bytes_next = {8'd0, bytes.table_byte};
        byte_phase_next = PHASE_SECOND;
      end else if (phase0 == PHASE_SECOND) begin
        value           = {4'd0, bytes.table_byte[3:0], held0[7:0]};
        held_bytes_next = {bytes.table_byte, held0[7:0]};
        byte_phase_next = PHASE_THIRD;
        emit            = 1'b1;
      end else begin
        value           = {4'd0, bytes.table_byte, held0[15:12]};
        byte_phase_next = PHASE_FIRST;
        emit            = 1'b1;
      end
    end else begin
      if (phase0 == PHASE_FIRST) begin
        held_bytes_next = {8'd0, bytes.table_byte};
        byte_phase_next = PHASE_SECOND;
      end else begin
        value           = {bytes.table_byte, held0[7:0]};
        byte_phase_next = PHASE_FIRST;
        emit            = 1'b1;
      end
    end

    next_cluster_next  = emit ? nc0 + 17'd1 : nc0;
    fresh_pending_next = emit ? 1'b0 : fresh0;
  end

  // word pushed into the queue
  always_comb begin
    push_valid        = accept && emit;
    push_word.cluster = nc0[CLUSTER_W-1:0];
    push_word.value   = value;
    push_word.last    = nc0[CLUSTER_W-1:0] == cluster_count;
    push_word.fresh   = fresh0;
  end

  // unpacking state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= PHASE_FIRST;
      held_bytes     <= '0;
      next_cluster   <= FIRST_CLUSTER;
      header_skipped <= 1'b0;
      fresh_pending  <= 1'b1;
    end else if (accept) begin
      byte_phase     <= byte_phase_next;
      held_bytes     <= held_bytes_next;
      next_cluster   <= next_cluster_next;
      header_skipped <= header_skipped_next;
      fresh_pending  <= fresh_pending_next;
    end
  end

endmodule

/* sv/fftu_queue.sv */
module fftu_queue
  import fftu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_word,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_word
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_FULL;
  assign pop_valid  = count != '0;
  assign pop_word   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

/* sv/fftu_back.sv */
module fftu_back
  import fftu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         pop_valid,
  output logic         pop_ready,
  input  entry_t       pop_word,
  fftu_entry_if.source entries
);

  logic                 out_valid;
  logic [CLUSTER_W-1:0] highest;
  logic [CLUSTER_W-1:0] highest_next;
  logic                 do_pop;

  assign pop_ready     = !out_valid || entries.ready;
  assign do_pop        = pop_valid && pop_ready;
  assign entries.valid = out_valid;

  // running highest nonzero cluster, cleared by a table start
  always_comb begin
    highest_next = pop_word.fresh ? '0 : highest;
    if (pop_word.value != '0) begin
      highest_next = pop_word.cluster;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      highest   <= '0;
    end else if (do_pop) begin
      out_valid <= 1'b1;
      highest   <= highest_next;
    end else if (entries.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (do_pop) begin
      entries.cluster_number <= pop_word.cluster;
      entries.entry_value    <= pop_word.value;
      entries.highest_used   <= highest_next;
      entries.last_entry     <= pop_word.last;
    end
  end

endmodule

/* sv/fat12_fat16_table_unpacker.sv */
// FAT12/FAT16 allocation table unpacker
//
// bytes: one raw table byte per word, table_start marks byte 0 of a table
// entries: one word per cluster from 2 up to cluster_count, carrying the
//   cluster number, its entry, the highest nonzero cluster so far and a
//   flag on the final cluster
// cfg_wr_en / cfg_wr_data: writes cluster_count; write only while idle
//   below 4096 the table holds 12-bit entries, otherwise 16-bit entries
//
// throughput: one byte per cycle; the front takes a byte whenever the
//   queue has room, and the back drains one word per cycle while the
//   receiver takes them; the byte that completes an entry puts its word
//   into a queue slot, and from there the word moves into the output
//   register that drives entries
// reset: cluster_count goes to 2 and unpacking restarts as on a table start
// stall: the output register holds its word; the queue fills and then
//   bytes.ready drops until the receiver takes words again
module fat12_fat16_table_unpacker
  import fftu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CLUSTER_W-1:0] cfg_wr_data,
  fftu_byte_if.sink            bytes,
  fftu_entry_if.source         entries
);

  logic [CLUSTER_W-1:0] cluster_count;
  logic                 push_valid;
  logic                 push_ready;
  entry_t               push_word;
  logic                 pop_valid;
  logic                 pop_ready;
  entry_t               pop_word;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= 16'd2;
    end else if (cfg_wr_en) begin
      cluster_count <= cfg_wr_data;
    end
  end

  fftu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cluster_count (cluster_count),
    .bytes         (bytes),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_word     (push_word)
  );

  fftu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  fftu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .entries   (entries)
  );

endmodule
